// File: design/srm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srm_pkg
// Types, constants and the arctangent table of the stage rotation datapath.
// ----------------------------------------------------------------------------
package srm_pkg;

  localparam int XW      = 36;   // cordic x / y width
  localparam int ZW      = 33;   // cordic residual angle width
  localparam int DW      = XW + 1;
  localparam int FRAC    = 16;
  localparam int MW      = 19;   // move field width
  localparam int ITERS   = 28;

  localparam logic signed [XW-1:0] START      = 36'sd3658288128;
  localparam logic [31:0]          OFFSET_135 = 32'h6000_0000;
  localparam logic [MW-2:0]        MOVE_LIMIT = 18'd183848;

  typedef struct packed {
    logic                 neg;
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } cord_t;

  // two cosines run side by side: a is the new angle, b the old one
  typedef struct packed {
    cord_t a;
    cord_t b;
  } pair_t;

  function automatic logic [31:0] atan_entry(int i);
    logic [31:0] v;
    case (i)
      0:       v = 32'h2000_0000;
      1:       v = 32'h12E4_051E;
      2:       v = 32'h09FB_385B;
      3:       v = 32'h0511_11D4;
      4:       v = 32'h028B_0D43;
      5:       v = 32'h0145_D7E1;
      6:       v = 32'h00A2_F61E;
      7:       v = 32'h0051_7C55;
      8:       v = 32'h0028_BE53;
      9:       v = 32'h0014_5F2F;
      10:      v = 32'h000A_2F98;
      11:      v = 32'h0005_17CC;
      12:      v = 32'h0002_8BE6;
      13:      v = 32'h0001_45F3;
      14:      v = 32'h0000_A2FA;
      15:      v = 32'h0000_517D;
      16:      v = 32'h0000_28BE;
      17:      v = 32'h0000_145F;
      18:      v = 32'h0000_0A30;
      19:      v = 32'h0000_0518;
      20:      v = 32'h0000_028C;
      21:      v = 32'h0000_0146;
      22:      v = 32'h0000_00A3;
      23:      v = 32'h0000_0051;
      24:      v = 32'h0000_0029;
      25:      v = 32'h0000_0014;
      26:      v = 32'h0000_000A;
      27:      v = 32'h0000_0005;
      default: v = 32'h0000_0000;
    endcase
    return v;
  endfunction

  // fold a binary angle into [-90deg, +90deg), remember to negate the cosine
  function automatic cord_t fold(logic [31:0] ang);
    logic        neg;
    logic [31:0] a;
    cord_t       c;
    neg   = ang[31] ^ ang[30];
    a     = neg ? {~ang[31], ang[30:0]} : ang;
    c.neg = neg;
    c.x   = START;
    c.y   = '0;
    c.z   = {a[31], a};
    return c;
  endfunction

endpackage

// File: design/srm_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srm_cell
// One cordic rotation step for both cosine lanes, registered.
// ----------------------------------------------------------------------------
module srm_cell #(
  parameter int ITER = 0
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  srm_pkg::pair_t data_i,
  output logic          valid_o,
  output srm_pkg::pair_t data_o
);
  import srm_pkg::*;

  localparam logic signed [ZW-1:0] Atan = ZW'({1'b0, atan_entry(ITER)});

  function automatic cord_t rotate(cord_t c);
    cord_t r;
    r = c;
    if (!c.z[ZW-1]) begin
      r.x = c.x - (c.y >>> ITER);
      r.y = c.y + (c.x >>> ITER);
      r.z = c.z - Atan;
    end else begin
      r.x = c.x + (c.y >>> ITER);
      r.y = c.y - (c.x >>> ITER);
      r.z = c.z + Atan;
    end
    return r;
  endfunction

  logic  valid_q;
  pair_t data_q, data_d;

  always_comb begin
    data_d.a = rotate(data_i.a);
    data_d.b = rotate(data_i.b);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// File: design/srm_post.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srm_post
// Cosine difference, truncation toward zero and saturation of the move.
// ----------------------------------------------------------------------------
module srm_post (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  srm_pkg::pair_t                data_i,
  output logic                          valid_o,
  output logic signed [srm_pkg::MW-1:0] move_o
);
  import srm_pkg::*;

  localparam int MagW = DW - FRAC;

  logic                 v1_q, v2_q;
  logic signed [XW-1:0] cos_a, cos_b;
  logic signed [DW-1:0] diff_d, diff_q, abs_d;
  logic [MagW-1:0]      mag_q;
  logic                 sign_q;
  logic [MW-2:0]        clamped;

  always_comb begin
    cos_a  = data_i.a.neg ? -data_i.a.x : data_i.a.x;
    cos_b  = data_i.b.neg ? -data_i.b.x : data_i.b.x;
    diff_d = {cos_a[XW-1], cos_a} - {cos_b[XW-1], cos_b};
    abs_d  = diff_q[DW-1] ? -diff_q : diff_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      diff_q <= diff_d;
    end
    if (v1_q) begin
      mag_q  <= abs_d[DW-1:FRAC];
      sign_q <= diff_q[DW-1];
    end
  end

  always_comb begin
    clamped = (mag_q > MagW'(MOVE_LIMIT)) ? MOVE_LIMIT : mag_q[MW-2:0];
    move_o  = sign_q ? -$signed({1'b0, clamped}) : $signed({1'b0, clamped});
  end

  assign valid_o = v2_q;

endmodule

// File: design/stage_rotation_axis_moves_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stage_rotation_axis_moves_top
// Rotation step per stage to x1 / x2 / y axis moves through a cordic chain.
// ----------------------------------------------------------------------------
// channel | direction | handshake              | fields
// in      | input     | in_valid_i / in_stall_o | stage_index_i, rotation_step_i
// out     | output    | out_valid_o / out_stall_i | x1_move_o, x2_move_o, y_move_o
//
// path from acceptance to result: the start register loads at the accepting
// edge, then 28 cordic cells, two post stages and the output register.
// the next item is taken in the cycle after the result is taken, so one item
// is in flight at a time.
// reset clears all stage angles to zero and empties the block.
// out_stall_i holds the result in its output register; input stays stalled.
// ----------------------------------------------------------------------------
module stage_rotation_axis_moves_top #(
  parameter int NUM_STAGES = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    stage_index_i,
  input  logic signed [31:0]            rotation_step_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [srm_pkg::MW-1:0] x1_move_o,
  output logic signed [srm_pkg::MW-1:0] x2_move_o,
  output logic signed [srm_pkg::MW-1:0] y_move_o
);
  import srm_pkg::*;

  // only four stages can be named by a two bit index
  localparam int Stored = (NUM_STAGES < 4) ? NUM_STAGES : 4;
  localparam int IdxW   = (Stored > 1) ? $clog2(Stored) : 1;

  logic [31:0]          angles_q [Stored];
  logic                 busy_q, out_valid_q, zero_q;
  logic signed [MW-1:0] move_q;
  logic                 in_accept, out_accept, idx_ok;
  logic [IdxW-1:0]      idx;
  logic [31:0]          phi, phi_next;

  logic                 start_valid_q;
  pair_t                start_q;
  logic                 chain_valid [ITERS+1];
  pair_t                chain_data  [ITERS+1];
  pair_t                start_d;
  logic                 res_valid;
  logic signed [MW-1:0] res_move;

  assign in_accept  = in_valid_i && !busy_q;
  assign out_accept = out_valid_q && !out_stall_i;
  assign idx_ok     = 32'(stage_index_i) < 32'(NUM_STAGES);
  assign idx        = stage_index_i[IdxW-1:0];

  always_comb begin
    phi       = idx_ok ? angles_q[idx] : '0;
    phi_next  = phi + rotation_step_i;
    start_d.a = fold(phi_next + OFFSET_135);
    start_d.b = fold(phi + OFFSET_135);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Stored; i++) begin
        angles_q[i] <= '0;
      end
      busy_q        <= 1'b0;
      out_valid_q   <= 1'b0;
      start_valid_q <= 1'b0;
    end else begin
      start_valid_q <= in_accept;
      if (in_accept) begin
        busy_q <= 1'b1;
        if (idx_ok) begin
          angles_q[idx] <= phi_next;
        end
      end
      if (res_valid) begin
        out_valid_q <= 1'b1;
      end else if (out_accept) begin
        out_valid_q <= 1'b0;
        busy_q      <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      start_q <= start_d;
      zero_q  <= !idx_ok;
    end
    if (res_valid) begin
      move_q <= zero_q ? '0 : res_move;
    end
  end

  assign chain_valid[0] = start_valid_q;
  assign chain_data[0]  = start_q;

  for (genvar g = 0; g < ITERS; g++) begin : g_cell
    srm_cell #(
      .ITER(g)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(chain_valid[g]),
      .data_i (chain_data[g]),
      .valid_o(chain_valid[g+1]),
      .data_o (chain_data[g+1])
    );
  end

  srm_post u_post (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(chain_valid[ITERS]),
    .data_i (chain_data[ITERS]),
    .valid_o(res_valid),
    .move_o (res_move)
  );

  assign in_stall_o  = busy_q;
  assign out_valid_o = out_valid_q;
  assign x1_move_o   = move_q;
  assign x2_move_o   = move_q;
  assign y_move_o    = move_q;

`ifndef SYNTH
  a_out_needs_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> busy_q)
    else $error("result shown with no item in flight");

  a_start_from_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chain_valid[0] |-> $past(in_accept))
    else $error("cordic chain started without an accepted item");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> !out_valid_q)
    else $error("new result while output register still full");

  a_free_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_accept |=> !in_stall_o)
    else $error("input still stalled after result was taken");
`endif

endmodule

// File: dv/stage_rotation_axis_moves_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stage_rotation_axis_moves_top_test
// Drives rotation steps into the stage kinematics block and checks every
// x1 / x2 / y move against a bit-true cordic predictor with its own copy of
// the per-stage angles. Random idling on both sides, a long output hold-off
// and a drain pause exercise the valid / stall handshake.
// ----------------------------------------------------------------------------
module stage_rotation_axis_moves_top_test;

  localparam int NUM_STAGES   = 4;
  localparam int CLK_HALF     = 4;
  localparam int RESET_CYCLES = 5;
  localparam int LATENCY      = 31;
  localparam int HOLD_CYCLES  = 300;
  // about 1600 items plus stalls and gaps, taken several times over
  localparam int CYCLE_LIMIT  = 800000;
  localparam int RANDOM_ITEMS = 1500;

  localparam int           CORD_STEPS = 28;
  localparam longint       CORD_START = 64'sd3658288128;
  localparam logic [31:0]  ANGLE_135  = 32'h6000_0000;
  localparam longint       MOVE_SAT   = 64'sd183848;

  localparam longint ATAN_STEP [CORD_STEPS] = '{
    64'h2000_0000, 64'h12E4_051E, 64'h09FB_385B, 64'h0511_11D4, 64'h028B_0D43,
    64'h0145_D7E1, 64'h00A2_F61E, 64'h0051_7C55, 64'h0028_BE53, 64'h0014_5F2F,
    64'h000A_2F98, 64'h0005_17CC, 64'h0002_8BE6, 64'h0001_45F3, 64'h0000_A2FA,
    64'h0000_517D, 64'h0000_28BE, 64'h0000_145F, 64'h0000_0A30, 64'h0000_0518,
    64'h0000_028C, 64'h0000_0146, 64'h0000_00A3, 64'h0000_0051, 64'h0000_0029,
    64'h0000_0014, 64'h0000_000A, 64'h0000_0005
  };

  typedef struct {
    logic signed [srm_pkg::MW-1:0] x1;
    logic signed [srm_pkg::MW-1:0] x2;
    logic signed [srm_pkg::MW-1:0] y;
  } axis_move_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          in_valid_i = 1'b0;
  logic                          in_stall_o;
  logic [1:0]                    stage_index_i = '0;
  logic signed [31:0]            rotation_step_i = '0;
  logic                          out_valid_o;
  logic                          out_stall_i = 1'b0;
  logic signed [srm_pkg::MW-1:0] x1_move_o;
  logic signed [srm_pkg::MW-1:0] x2_move_o;
  logic signed [srm_pkg::MW-1:0] y_move_o;

  logic [31:0] stage_phase [NUM_STAGES];
  axis_move_t  moves_due [$];
  int          mismatch_count = 0;
  int          cycle_count = 0;
  bit          idle_on = 1'b1;
  bit          hold_req = 1'b0;
  logic        hold_on = 1'b0;

  stage_rotation_axis_moves_top #(
    .NUM_STAGES (NUM_STAGES)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .stage_index_i   (stage_index_i),
    .rotation_step_i (rotation_step_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .x1_move_o       (x1_move_o),
    .x2_move_o       (x2_move_o),
    .y_move_o        (y_move_o)
  );

  initial begin
    forever #(CLK_HALF) clk_i = ~clk_i;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("stage_rotation_axis_moves_top verification failed");
    $finish;
  end

  // R*1000*cos(a) with 16 fractional bits
  function automatic longint scaled_cosine(logic [31:0] ang);
    logic   flip;
    longint x;
    longint y;
    longint z;
    longint nx;
    flip = ang[31] ^ ang[30];
    if (flip) ang = ang + 32'h8000_0000;
    x = CORD_START;
    y = 0;
    z = longint'(signed'(ang));
    for (int i = 0; i < CORD_STEPS; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z  = z - ATAN_STEP[i];
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z  = z + ATAN_STEP[i];
      end
      x = nx;
    end
    return flip ? -x : x;
  endfunction

  // displacement of all three axes; advances the stage angle
  function automatic axis_move_t predict_axis_move(logic [1:0] stage, logic [31:0] step);
    axis_move_t  mv;
    logic [31:0] phi;
    longint      d;
    longint      m;
    if (int'(stage) >= NUM_STAGES) begin
      mv.x1 = '0;
      mv.x2 = '0;
      mv.y  = '0;
      return mv;
    end
    phi = stage_phase[stage];
    d = scaled_cosine(phi + step + ANGLE_135) - scaled_cosine(phi + ANGLE_135);
    if (d < 0) m = -((-d) >> 16);
    else m = d >> 16;
    if (m > MOVE_SAT) m = MOVE_SAT;
    if (m < -MOVE_SAT) m = -MOVE_SAT;
    mv.x1 = m[srm_pkg::MW-1:0];
    mv.x2 = m[srm_pkg::MW-1:0];
    mv.y  = m[srm_pkg::MW-1:0];
    stage_phase[stage] = phi + step;
    return mv;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch at cycle %0d: %s got %0d want %0d", cycle_count, what, got, want);
    mismatch_count++;
  endtask

  task automatic send_rotation(logic [1:0] stage, logic [31:0] step);
    if (idle_on) begin
      while ($urandom_range(99) < 21) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
      // now and then a longer gap so it lands anywhere in the block's work
      if ($urandom_range(19) == 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(40, 1)) @(posedge clk_i);
      end
    end
    in_valid_i      <= 1'b1;
    stage_index_i   <= stage;
    rotation_step_i <= step;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    moves_due.push_back(predict_axis_move(stage, step));
  endtask

  // stop offering so the last item is not taken twice
  task automatic wait_moves_drained();
    in_valid_i <= 1'b0;
    while (moves_due.size() != 0) @(posedge clk_i);
  endtask

  // output side: check each item taken, then pick the stall for the next cycle
  initial begin
    axis_move_t want;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
        if (moves_due.size() == 0) begin
          report_mismatch("unexpected item x1_move", int'(x1_move_o), 0);
        end else begin
          want = moves_due.pop_front();
          if (x1_move_o !== want.x1) report_mismatch("x1_move", int'(x1_move_o), int'(want.x1));
          if (x2_move_o !== want.x2) report_mismatch("x2_move", int'(x2_move_o), int'(want.x2));
          if (y_move_o !== want.y) report_mismatch("y_move", int'(y_move_o), int'(want.y));
        end
      end
      out_stall_i <= hold_on || (idle_on && $urandom_range(99) < 21);
    end
  end

  // long receiver hold-off, counted here
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_on <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_on <= 1'b0;
      end
    end
  end

  task automatic test_directed();
    // zero step, unit steps, quarter turns and the extremes of the signed range
    send_rotation(2'd0, 32'h0000_0000);
    send_rotation(2'd0, 32'h0000_0001);
    send_rotation(2'd0, 32'hFFFF_FFFF);
    send_rotation(2'd0, 32'h7FFF_FFFF);
    send_rotation(2'd0, 32'h8000_0000);
    send_rotation(2'd0, 32'h4000_0000);
    send_rotation(2'd0, 32'hC000_0000);
    // phi + 135deg at zero, then half turns: largest moves, saturated
    send_rotation(2'd1, 32'hA000_0000);
    send_rotation(2'd1, 32'h8000_0000);
    send_rotation(2'd1, 32'h8000_0000);
    // accumulated angle wraps past a full turn
    send_rotation(2'd2, 32'h7FFF_FFFF);
    send_rotation(2'd2, 32'h7FFF_FFFF);
    send_rotation(2'd2, 32'h7FFF_FFFF);
    send_rotation(2'd2, 32'h8000_0001);
    send_rotation(2'd3, 32'h0000_0000);
    send_rotation(2'd3, 32'h5555_5555);
    send_rotation(2'd3, 32'hAAAA_AAAA);
    send_rotation(2'd3, 32'h0000_0001);
    send_rotation(2'd3, 32'hFFFF_FFFF);
    send_rotation(2'd1, 32'h1000_0000);
    send_rotation(2'd0, 32'h2000_0000);
  endtask

  task automatic test_random_steps();
    logic [31:0] step;
    int          pick;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // a stretch with no idling on either side
      idle_on = !(n >= 600 && n < 800);
      pick = $urandom_range(99);
      if (pick < 60) begin
        step = $urandom;
      end else if (pick < 75) begin
        step = $urandom_range(2000) - 1000;
      end else if (pick < 85) begin
        case ($urandom_range(8))
          0:       step = 32'h0000_0000;
          1:       step = 32'h0000_0001;
          2:       step = 32'hFFFF_FFFF;
          3:       step = 32'h7FFF_FFFF;
          4:       step = 32'h8000_0000;
          5:       step = 32'h4000_0000;
          6:       step = 32'hC000_0000;
          7:       step = 32'hA000_0000;
          default: step = 32'h2000_0000;
        endcase
      end else begin
        // eighth turns with a little jitter hit the fold boundaries
        step = ($urandom_range(7) << 29) + ($urandom_range(64) - 32);
      end
      send_rotation(2'($urandom_range(NUM_STAGES - 1)), step);
    end
    idle_on = 1'b1;
  endtask

  task automatic test_output_hold();
    hold_req = 1'b1;
    for (int n = 0; n < 8; n++) begin
      send_rotation(2'($urandom_range(NUM_STAGES - 1)), $urandom);
    end
  endtask

  task automatic test_drain_pause();
    for (int r = 0; r < 5; r++) begin
      for (int n = 0; n < 8; n++) begin
        send_rotation(2'($urandom_range(NUM_STAGES - 1)), $urandom);
      end
      wait_moves_drained();
    end
  endtask

  initial begin
    for (int s = 0; s < NUM_STAGES; s++) stage_phase[s] = '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_output_hold();
    test_random_steps();
    test_drain_pause();
    wait_moves_drained();
    repeat (LATENCY + 10) @(posedge clk_i);
    if (mismatch_count == 0 && moves_due.size() == 0) begin
      $display("stage_rotation_axis_moves_top verification clean");
    end else begin
      $display("stage_rotation_axis_moves_top verification failed");
    end
    $finish;
  end

endmodule

// File: sim.f
design/srm_pkg.sv
design/srm_cell.sv
design/srm_post.sv
design/stage_rotation_axis_moves_top.sv
dv/stage_rotation_axis_moves_top_test.sv
